@@ rtl/core/multilevel_ready_queue_defines.svh @@
// Assertion macros used by the checker file.
`ifndef MULTILEVEL_READY_QUEUE_DEFINES_SVH
`define MULTILEVEL_READY_QUEUE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define MRQ_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MRQ_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

@@ rtl/core/mrq_pkg.sv @@
`default_nettype none
package mrq_pkg;
    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_PEEK   = 3'd2;
    localparam logic [2:0] OP_BPUSH  = 3'd3;
    localparam logic [2:0] OP_BREM   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] task_id;
        logic [7:0] priority_req;
        logic [3:0] slot_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] task_out;
        logic [2:0] level_out;
        logic [3:0] blocked_slot;
    } out_item_t;

    // Command from the sequencer to the blocked-list cells.
    typedef struct packed {
        logic push;
        logic shift;
    } cell_ctl_t;
endpackage
`default_nettype wire

@@ rtl/core/mrq_cell.sv @@
`default_nettype none
// One blocked-list slot: load on push, take the upper neighbor on shift.
module mrq_cell #(
    parameter int ID_BITS = 8
) (
    input  wire                     clk,
    input  wire mrq_pkg::cell_ctl_t ctl,
    input  wire                     sel_push,
    input  wire                     sel_shift,
    input  wire  [ID_BITS-1:0]      push_id,
    input  wire  [ID_BITS-1:0]      upper_id,
    output logic [ID_BITS-1:0]      id
);
    import mrq_pkg::*;

    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;

    always_comb
    begin
        id_next = id_reg;
        if (ctl.push && sel_push)
        begin
            id_next = push_id;
        end
        else if (ctl.shift && sel_shift)
        begin
            id_next = upper_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;
endmodule
`default_nettype wire

@@ rtl/core/multilevel_ready_queue.sv @@
`default_nettype none
// Channel | Dir | Payload     | Handshake
// in      | in  | in_item_t   | in_valid / in_ready
// out     | out | out_item_t  | out_valid / out_ready
// Ready push: scan, then result register; pop/peek: level scan, store read, result register.
// Blocked push loads a cell at the scan; blocked remove shifts the cells above the slot, one cell shift a cycle.
// The blocked-list cell chain makes blocked removes the slowest items.
// One item at a time; in_ready drops while an item is at work or its result is held.
// rst_n clears level pointers, counts and the blocked count; stores are not cleared.
// A stalled result holds in the output register until out_ready.
module multilevel_ready_queue #(
    parameter int LEVELS    = 8,
    parameter int MAX_TASKS = 16,
    parameter int ID_BITS   = 8
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire mrq_pkg::in_item_t   in_data,
    output logic                     out_valid,
    input  wire                      out_ready,
    output mrq_pkg::out_item_t       out_data
);
    import mrq_pkg::*;

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int AW = $clog2(LEVELS * MAX_TASKS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    in_item_t   item_reg;
    out_item_t  res_reg, res_next;

    logic [PW-1:0] head_reg  [LEVELS];
    logic [PW-1:0] tail_reg  [LEVELS];
    logic [CW-1:0] count_reg [LEVELS];
    logic [CW-1:0] bcount_reg;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic [CW-1:0] k_reg, k_next;

    logic [ID_BITS-1:0] ready_mem [LEVELS*MAX_TASKS];
    logic [ID_BITS-1:0] rd_reg;

    logic               wr_en, rd_en, pop_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [LW-1:0]      clamp_lvl;
    logic               any_ne;
    logic [LW-1:0]      first_ne;
    logic [ID_BITS-1:0] in_id;
    cell_ctl_t          cctl;
    logic [ID_BITS-1:0] cell_id [MAX_TASKS];
    logic               bpush_en, brem_done;

    assign in_id = ID_BITS'(item_reg.task_id);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        if ({24'd0, item_reg.priority_req} >= LEVELS)
            clamp_lvl = LW'(LEVELS - 1);
        else
            clamp_lvl = item_reg.priority_req[LW-1:0];
    end

    always_comb
    begin
        any_ne = 1'b0;
        first_ne = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                any_ne = 1'b1;
                first_ne = LW'(l);
            end
        end
    end

    assign wr_addr = AW'(clamp_lvl) * AW'(MAX_TASKS) + AW'(tail_reg[clamp_lvl]);
    assign rd_addr = AW'(lvl_reg) * AW'(MAX_TASKS) + AW'(head_reg[lvl_reg]);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ready_mem[wr_addr] <= in_id;
        if (rd_en)
            rd_reg <= ready_mem[rd_addr];
    end

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++)
        begin : g_cell
            mrq_cell #(.ID_BITS(ID_BITS)) u_cell (
                .clk       (clk),
                .ctl       (cctl),
                .sel_push  (bcount_reg == CW'(g)),
                .sel_shift (k_reg == CW'(g)),
                .push_id   (in_id),
                .upper_id  (cell_id[(g + 1) % MAX_TASKS]),
                .id        (cell_id[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        lvl_next   = lvl_reg;
        k_next     = k_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        pop_en     = 1'b0;
        bpush_en   = 1'b0;
        brem_done  = 1'b0;
        cctl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                res_next = '0;
                state_next = S_OUT;
                case (item_reg.operation)
                    OP_PUSH:
                    begin
                        if (count_reg[clamp_lvl] >= CW'(MAX_TASKS))
                            res_next.status = ST_FULL;
                        else
                            wr_en = 1'b1;
                    end
                    OP_POP, OP_PEEK:
                    begin
                        if (!any_ne)
                            res_next.status = ST_EMPTY;
                        else
                        begin
                            lvl_next = first_ne;
                            state_next = S_READ;
                        end
                    end
                    OP_BPUSH:
                    begin
                        if (bcount_reg >= CW'(MAX_TASKS))
                            res_next.status = ST_FULL;
                        else
                        begin
                            bpush_en = 1'b1;
                            cctl.push = 1'b1;
                            res_next.blocked_slot = 4'(bcount_reg);
                        end
                    end
                    OP_BREM:
                    begin
                        if (CW'(item_reg.slot_index) >= bcount_reg
                            || 32'(item_reg.slot_index) >= MAX_TASKS)
                            res_next.status = ST_BAD;
                        else
                        begin
                            res_next.task_out = 8'(cell_id[PW'(item_reg.slot_index)]);
                            k_next = CW'(item_reg.slot_index);
                            state_next = S_SHIFT;
                        end
                    end
                    default:
                        res_next.status = ST_BAD;
                endcase
            end
            S_READ:
            begin
                rd_en = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (item_reg.operation == OP_BREM)
                begin
                    // advance the gap one cell per cycle
                    if (k_reg + 1'b1 < bcount_reg)
                    begin
                        cctl.shift = 1'b1;
                        k_next = k_reg + 1'b1;
                    end
                    else
                    begin
                        brem_done = 1'b1;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    res_next.task_out = 8'(rd_reg);
                    res_next.level_out = 3'(lvl_reg);
                    pop_en = (item_reg.operation == OP_POP);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            item_reg <= in_data;
        res_reg <= res_next;
        lvl_reg <= lvl_next;
        k_reg   <= k_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            bcount_reg <= '0;
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                // wrap at the level depth
                tail_reg[clamp_lvl]  <= (tail_reg[clamp_lvl] == PW'(MAX_TASKS - 1))
                                        ? '0 : tail_reg[clamp_lvl] + 1'b1;
                count_reg[clamp_lvl] <= count_reg[clamp_lvl] + 1'b1;
            end
            if (pop_en)
            begin
                head_reg[lvl_reg]  <= (head_reg[lvl_reg] == PW'(MAX_TASKS - 1))
                                      ? '0 : head_reg[lvl_reg] + 1'b1;
                count_reg[lvl_reg] <= count_reg[lvl_reg] - 1'b1;
            end
            if (bpush_en)
                bcount_reg <= bcount_reg + 1'b1;
            if (brem_done)
                bcount_reg <= bcount_reg - 1'b1;
        end
    end

    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;
endmodule
`default_nettype wire

@@ rtl/core/mrq_checker.sv @@
`default_nettype none
`include "multilevel_ready_queue_defines.svh"
module mrq_checker (
    input wire                     clk,
    input wire                     rst_n,
    input wire                     in_valid,
    input wire                     in_ready,
    input wire                     out_valid,
    input wire                     out_ready,
    input wire mrq_pkg::out_item_t out_data
);
    import mrq_pkg::*;

    `MRQ_ASSERT_IMP(a_one_at_a_time, clk, rst_n, out_valid, !in_ready, "input open while result held")
    `MRQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
    `MRQ_ASSERT_IMP(a_empty_fields, clk, rst_n, out_valid && out_data.status == ST_EMPTY, out_data.task_out == 8'd0 && out_data.level_out == 3'd0, "empty result carries data")
    `MRQ_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready, "second transfer taken before result")
endmodule

bind multilevel_ready_queue mrq_checker u_mrq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none
module tb;
    import mrq_pkg::*;

    localparam int LEVELS = 8;
    localparam int MAX_TASKS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;

    multilevel_ready_queue dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    // Shadow copy of the queue state
    logic [7:0] level_ids [LEVELS][MAX_TASKS];
    int unsigned level_rd [LEVELS];
    int unsigned level_wr [LEVELS];
    int unsigned level_fill [LEVELS];
    logic [7:0] blocked_ids [MAX_TASKS];
    int unsigned blocked_fill;

    out_item_t pending_results[$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    bit stall_mode = 1'b0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic out_item_t predict_result(in_item_t item);
        out_item_t r;
        int lvl;
        r = '0;
        r.status = ST_OK;
        case (item.operation)
            OP_PUSH:
            begin
                lvl = (item.priority_req >= LEVELS) ? LEVELS - 1 : item.priority_req;
                if (level_fill[lvl] >= MAX_TASKS)
                    r.status = ST_FULL;
                else
                begin
                    level_ids[lvl][level_wr[lvl]] = item.task_id;
                    level_wr[lvl] = (level_wr[lvl] + 1) % MAX_TASKS;
                    level_fill[lvl]++;
                end
            end
            OP_POP, OP_PEEK:
            begin
                lvl = LEVELS;
                for (int l = LEVELS - 1; l >= 0; l--)
                    if (level_fill[l] != 0)
                        lvl = l;
                if (lvl == LEVELS)
                    r.status = ST_EMPTY;
                else
                begin
                    r.task_out = level_ids[lvl][level_rd[lvl]];
                    r.level_out = lvl[2:0];
                    if (item.operation == OP_POP)
                    begin
                        level_rd[lvl] = (level_rd[lvl] + 1) % MAX_TASKS;
                        level_fill[lvl]--;
                    end
                end
            end
            OP_BPUSH:
            begin
                if (blocked_fill >= MAX_TASKS)
                    r.status = ST_FULL;
                else
                begin
                    blocked_ids[blocked_fill] = item.task_id;
                    r.blocked_slot = blocked_fill[3:0];
                    blocked_fill++;
                end
            end
            OP_BREM:
            begin
                if (item.slot_index >= blocked_fill)
                    r.status = ST_BAD;
                else
                begin
                    r.task_out = blocked_ids[item.slot_index];
                    for (int k = item.slot_index; k + 1 < blocked_fill; k++)
                        blocked_ids[k] = blocked_ids[k + 1];
                    blocked_fill--;
                end
            end
            default: r.status = ST_BAD;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Send one item, sometimes after a random idle gap, and wait until it is taken
    task automatic send_op(logic [2:0] op, logic [7:0] id, logic [7:0] prio, logic [3:0] slot);
        in_item_t item;
        item.operation = op;
        item.task_id = id;
        item.priority_req = prio;
        item.slot_index = slot;
        if ($urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_result(item));
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (MAX_TASKS + 4) @(negedge clk);
    endtask

    task automatic test_ready_levels();
        send_op(OP_POP, 8'h00, 8'h00, 4'h0);
        send_op(OP_PEEK, 8'hFF, 8'hFF, 4'hF);
        send_op(OP_PUSH, 8'hFF, 8'hFF, 4'h0);
        send_op(OP_PUSH, 8'h00, 8'h00, 4'hF);
        send_op(OP_PUSH, 8'hA5, 8'd7, 4'h0);
        send_op(OP_PEEK, 8'h00, 8'h00, 4'h0);
        send_op(OP_POP, 8'h00, 8'h00, 4'h0);
        send_op(OP_POP, 8'h00, 8'h00, 4'h0);
        send_op(OP_POP, 8'h00, 8'h00, 4'h0);
        send_op(OP_POP, 8'h00, 8'h00, 4'h0);
    endtask

    // Fill one level past its depth, then empty it
    task automatic test_full_level();
        for (int i = 0; i < MAX_TASKS + 2; i++)
            send_op(OP_PUSH, i[7:0] + 8'h30, 8'd3, 4'h0);
        for (int i = 0; i < MAX_TASKS + 1; i++)
            send_op(OP_POP, 8'h00, 8'h00, 4'h0);
    endtask

    task automatic test_blocked_list();
        send_op(OP_BREM, 8'h00, 8'h00, 4'h0);
        for (int i = 0; i < MAX_TASKS + 1; i++)
            send_op(OP_BPUSH, 8'hC0 + i[7:0], 8'h00, 4'h0);
        send_op(OP_BREM, 8'h00, 8'h00, 4'hF);
        send_op(OP_BREM, 8'h00, 8'h00, 4'h0);
        send_op(OP_BREM, 8'h00, 8'h00, 4'h5);
        send_op(OP_BREM, 8'h00, 8'h00, 4'hF);
        while (blocked_fill != 0)
            send_op(OP_BREM, 8'h00, 8'h00, 4'h0);
    endtask

    task automatic test_unknown_ops();
        for (int op = 5; op < 8; op++)
            send_op(op[2:0], 8'hFF, 8'hFF, 4'hF);
    endtask

    // Mostly legal traffic, biased so queues both fill and drain
    task automatic test_random_traffic(int count);
        logic [2:0] op;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                op = OP_PUSH;
            else if (pick < 50)
                op = OP_POP;
            else if (pick < 60)
                op = OP_PEEK;
            else if (pick < 78)
                op = OP_BPUSH;
            else if (pick < 97)
                op = OP_BREM;
            else
                op = 3'($urandom_range(5, 7));
            send_op(op, 8'($urandom_range(0, 255)),
                8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                    : $urandom_range(0, 7)),
                4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                    : $urandom_range(0, (blocked_fill > 0) ? blocked_fill - 1 : 0)));
            if (i == count / 2)
                drain_results();
        end
    endtask

    // Receiver stall pattern: alternate between free-running and choppy stretches
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= ~stall_mode;
        out_ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result status", int'(out_data.status), -1);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch("status", int'(out_data.status), int'(want.status));
                if (out_data.task_out !== want.task_out)
                    report_mismatch("task_out", int'(out_data.task_out),
                        int'(want.task_out));
                if (out_data.level_out !== want.level_out)
                    report_mismatch("level_out", int'(out_data.level_out),
                        int'(want.level_out));
                if (out_data.blocked_slot !== want.blocked_slot)
                    report_mismatch("blocked_slot", int'(out_data.blocked_slot),
                        int'(want.blocked_slot));
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        blocked_fill = 0;
        for (int l = 0; l < LEVELS; l++)
        begin
            level_rd[l] = 0;
            level_wr[l] = 0;
            level_fill[l] = 0;
        end
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_ready_levels();
        test_full_level();
        test_blocked_list();
        test_unknown_ops();
        drain_results();
        test_random_traffic(1800);
        drain_results();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
